>>> src/bfb_pkg.sv
// ----------------------------------------------------------------------------
// bfb_pkg
// Shared types and constants of the beacon frame builder: frame layout
// offsets, the fixed RSN element, register indexes and the held request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfb_pkg;

    // sequence counter table
    localparam int MAX_NETWORKS = 8;
    localparam int SLOT_W       = 3;
    localparam int SEQ_W        = 16;

    // field widths
    localparam int MAC_W      = 48;
    localparam int CHAN_W     = 8;
    localparam int SSID_LEN_W = 6;
    localparam int SSID_MAX   = 32;
    localparam int SSID_W     = SSID_MAX * 8;
    localparam int WORD_W     = 64;
    localparam int CNT_W      = 4;
    localparam int POS_W      = 7;
    localparam int WIDX_W     = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAC_W;
    localparam logic [CFG_IDX_W-1:0] REG_DA_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 2'd1;

    localparam logic [MAC_W-1:0]  DA_ADDR_RST = {MAC_W{1'b1}};
    localparam logic [CHAN_W-1:0] CHANNEL_RST = 8'd1;

    // byte offsets in the frame
    localparam logic [POS_W-1:0] OFS_RT_LEN   = 7'd2;
    localparam logic [POS_W-1:0] OFS_FC       = 7'd8;
    localparam logic [POS_W-1:0] OFS_DEST     = 7'd12;
    localparam logic [POS_W-1:0] OFS_SRC      = 7'd18;
    localparam logic [POS_W-1:0] OFS_BSSID    = 7'd24;
    localparam logic [POS_W-1:0] OFS_SEQ_HI   = 7'd30;
    localparam logic [POS_W-1:0] OFS_SEQ_LO   = 7'd31;
    localparam logic [POS_W-1:0] OFS_TSTAMP   = 7'd32;
    localparam logic [POS_W-1:0] OFS_INTERVAL = 7'd40;
    localparam logic [POS_W-1:0] OFS_CAP_LO   = 7'd42;
    localparam logic [POS_W-1:0] OFS_CAP_HI   = 7'd43;
    localparam logic [POS_W-1:0] OFS_SSID_LEN = 7'd45;
    localparam logic [POS_W-1:0] OFS_TAIL     = 7'd46;
    localparam logic [POS_W-1:0] FRAME_FIXED  = 7'd52;
    localparam logic [POS_W-1:0] TRAILER_LEN  = 7'd6;
    localparam logic [POS_W-1:0] RSN_LEN      = 7'd22;
    localparam int RSN_IDX_W = 5;

    // fixed RSN element
    localparam logic [7:0] RSN_ELEM [22] = '{
        8'h30, 8'h14, 8'h01, 8'h00, 8'h00, 8'h0f, 8'hac, 8'h02, 8'h01, 8'h00, 8'h00,
        8'h0f, 8'hac, 8'h02, 8'h01, 8'h00, 8'h00, 8'h0f, 8'hac, 8'h02, 8'h00, 8'h00
    };

    // request held while its words go out
    typedef struct packed {
        logic [SEQ_W-1:0]      seq;
        logic [MAC_W-1:0]      src_mac;
        logic [SSID_W-1:0]     ssid;
        logic [SSID_LEN_W-1:0] ssid_len;
        logic                  wpa;
        logic [POS_W-1:0]      total;
        logic [WIDX_W-1:0]     last_idx;
    } bfb_item_t;

    // sequence counter bump request
    typedef struct packed {
        logic              inc;
        logic [SLOT_W-1:0] slot;
    } bfb_seq_req_t;

endpackage

`default_nettype wire

>>> src/bfb_if.sv
// ----------------------------------------------------------------------------
// bfb_if
// Valid/ready channels of the beacon frame builder: request and frame word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfb_req_if;
    import bfb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SLOT_W-1:0]     network_slot;
    logic [MAC_W-1:0]      source_mac;
    logic [SSID_LEN_W-1:0] ssid_length;
    logic [WORD_W-1:0]     ssid_bytes_low;
    logic [WORD_W-1:0]     ssid_bytes_second;
    logic [WORD_W-1:0]     ssid_bytes_third;
    logic [WORD_W-1:0]     ssid_bytes_high;
    logic                  wpa_enable;

    modport source (
        output valid, network_slot, source_mac, ssid_length, ssid_bytes_low,
               ssid_bytes_second, ssid_bytes_third, ssid_bytes_high, wpa_enable,
        input  ready
    );
    modport sink (
        input  valid, network_slot, source_mac, ssid_length, ssid_bytes_low,
               ssid_bytes_second, ssid_bytes_third, ssid_bytes_high, wpa_enable,
        output ready
    );
endinterface

interface bfb_word_if;
    import bfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] frame_word;
    logic [CNT_W-1:0]  byte_count;
    logic              last_word;

    modport source (
        output valid, frame_word, byte_count, last_word,
        input  ready
    );
    modport sink (
        input  valid, frame_word, byte_count, last_word,
        output ready
    );
endinterface

`default_nettype wire

>>> src/bfb_seq_table.sv
// ----------------------------------------------------------------------------
// bfb_seq_table
// Per-slot 16-bit sequence counters: read the selected slot, bump it when
// the request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfb_seq_table
    import bfb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [SLOT_W-1:0] rd_slot,
    output logic [SEQ_W-1:0]      rd_seq,
    input  wire bfb_seq_req_t     req
);

    logic [SEQ_W-1:0] seq_reg [MAX_NETWORKS];

    // current value of the addressed slot
    assign rd_seq = seq_reg[rd_slot];

    // counter update, wraps at 2^16
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NETWORKS; i++)
            begin
                seq_reg[i] <= '0;
            end
        end
        else if (req.inc)
        begin
            seq_reg[req.slot] <= seq_reg[req.slot] + SEQ_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> src/bfb_word_gen.sv
// ----------------------------------------------------------------------------
// bfb_word_gen
// Holds one request, builds the frame eight bytes at a time and drives
// the word channel through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfb_word_gen
    import bfb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [MAC_W-1:0]  da_addr,
    input  wire logic [CHAN_W-1:0] channel,
    input  wire logic [SEQ_W-1:0]  seq_value,
    output bfb_seq_req_t           seq_req,
    bfb_req_if.sink                req,
    bfb_word_if.source             frame
);

    bfb_item_t         item_reg;
    logic              item_valid_reg;
    logic [WIDX_W-1:0] widx_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              out_last_reg;

    logic              accept;
    logic              out_load;
    logic              is_last;
    logic [SSID_LEN_W-1:0] len_clamped;
    logic [POS_W-1:0]  total_next;
    logic [WORD_W-1:0] word_next;
    logic [CNT_W-1:0]  cnt_next;

    // one frame byte at a given position
    function automatic logic [7:0] frame_byte(
        input logic [POS_W-1:0]  pos,
        input bfb_item_t         it,
        input logic [MAC_W-1:0]  dmac,
        input logic [CHAN_W-1:0] ch
    );
        logic [POS_W-1:0] t;
        logic [POS_W-1:0] u;
        logic [2:0]       k;
        logic [7:0]       res;
        t   = pos - OFS_TAIL;
        u   = t - POS_W'(it.ssid_len);
        k   = '0;
        res = 8'h00;
        if (pos >= OFS_TAIL)
        begin
            // ssid bytes, then rate and channel elements, then rsn
            if (t < POS_W'(it.ssid_len))
            begin
                res = it.ssid[{t[4:0], 3'b000} +: 8];
            end
            else if (u < TRAILER_LEN)
            begin
                case (u[2:0])
                    3'd0:    res = 8'h01;
                    3'd1:    res = 8'h01;
                    3'd2:    res = 8'h82;
                    3'd3:    res = 8'h03;
                    3'd4:    res = 8'h01;
                    3'd5:    res = ch;
                    default: res = 8'h00;
                endcase
            end
            else if (it.wpa && (u < TRAILER_LEN + RSN_LEN))
            begin
                res = RSN_ELEM[RSN_IDX_W'(u - TRAILER_LEN)];
            end
        end
        else if (pos inside {[OFS_DEST:OFS_SRC - 7'd1]})
        begin
            k   = 3'(pos - OFS_DEST);
            res = dmac[{k, 3'b000} +: 8];
        end
        else if (pos inside {[OFS_SRC:OFS_BSSID - 7'd1]})
        begin
            k   = 3'(pos - OFS_SRC);
            res = it.src_mac[{k, 3'b000} +: 8];
        end
        else if (pos inside {[OFS_BSSID:OFS_SEQ_HI - 7'd1]})
        begin
            k   = 3'(pos - OFS_BSSID);
            res = it.src_mac[{k, 3'b000} +: 8];
        end
        else
        begin
            case (pos)
                OFS_RT_LEN:   res = 8'h08;
                OFS_FC:       res = 8'h80;
                OFS_SEQ_HI:   res = it.seq[15:8];
                OFS_SEQ_LO:   res = it.seq[7:0];
                OFS_TSTAMP:   res = 8'hff;
                OFS_INTERVAL: res = 8'h64;
                OFS_CAP_LO:   res = 8'h01;
                OFS_CAP_HI:   res = 8'h04;
                OFS_SSID_LEN: res = 8'(it.ssid_len);
                default:      res = 8'h00;
            endcase
        end
        return res;
    endfunction

    // handshakes
    assign is_last   = (widx_reg == item_reg.last_idx);
    assign out_load  = item_valid_reg && (!out_valid_reg || frame.ready);
    assign req.ready = !item_valid_reg || (out_load && is_last);
    assign accept    = req.valid && req.ready;

    assign seq_req.inc  = accept;
    assign seq_req.slot = req.network_slot;

    // request length and frame size
    always_comb
    begin
        len_clamped = (req.ssid_length > SSID_LEN_W'(SSID_MAX)) ?
                      SSID_LEN_W'(SSID_MAX) : req.ssid_length;
        total_next  = FRAME_FIXED + POS_W'(len_clamped) +
                      (req.wpa_enable ? RSN_LEN : '0);
    end

    // current word, one byte lane each
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            word_next[b*8 +: 8] = frame_byte({widx_reg, 3'(b)}, item_reg, da_addr, channel);
        end
        if (is_last && (item_reg.total[2:0] != 3'd0))
        begin
            cnt_next = CNT_W'(item_reg.total[2:0]);
        end
        else
        begin
            cnt_next = CNT_W'(8);
        end
    end

    // held request and word index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            widx_reg       <= '0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
            widx_reg       <= '0;
        end
        else if (out_load)
        begin
            item_valid_reg <= !is_last;
            widx_reg       <= widx_reg + WIDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.seq      <= seq_value;
            item_reg.src_mac  <= req.source_mac;
            item_reg.ssid     <= {req.ssid_bytes_high, req.ssid_bytes_third,
                                  req.ssid_bytes_second, req.ssid_bytes_low};
            item_reg.ssid_len <= len_clamped;
            item_reg.wpa      <= req.wpa_enable;
            item_reg.total    <= total_next;
            item_reg.last_idx <= WIDX_W'((total_next - 7'd1) >> 3);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg <= word_next;
            out_cnt_reg  <= cnt_next;
            out_last_reg <= is_last;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_word = out_word_reg;
    assign frame.byte_count = out_cnt_reg;
    assign frame.last_word  = out_last_reg;

    // checks
    a_widx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (widx_reg <= item_reg.last_idx))
        else $error("word index ran past the end of the frame");

    a_min_frame: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (item_reg.last_idx >= WIDX_W'(6)))
        else $error("frame shorter than seven words");

    a_full_inner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_cnt_reg == CNT_W'(8)))
        else $error("partial word before the end of a frame");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (item_valid_reg && (widx_reg == '0)))
        else $error("request taken but frame did not start at word zero");

endmodule

`default_nettype wire

>>> src/beacon_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// beacon_frame_builder_unit
// Builds a radiotap-prefixed 802.11 beacon per request and streams it as
// 64-bit words, earliest byte in the low bits.
//
//   channel  dir  handshake     beat
//   req      in   valid/ready   one beacon request
//   frame    out  valid/ready   one frame word, 1..8 bytes, last flag
//   wr_*     in   wr_en only    one register write (0 dest addr, 1 channel)
//
// A frame of 52 + ssid length (+22 with rsn) bytes leaves as 7 to 14 words,
// one per cycle, set by the single word builder behind the held request.
// The next request is taken in the cycle its predecessor's last word loads
// into the output register, so frames follow each other with no gap.
// Output stalls hold the word register; the request side stalls with it.
// Reset clears the sequence counters and sets broadcast and channel 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module beacon_frame_builder_unit
    import bfb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    bfb_req_if.sink                    req,
    bfb_word_if.source                 frame
);

    logic [MAC_W-1:0]  da_addr_reg;
    logic [CHAN_W-1:0] channel_reg;
    logic [SEQ_W-1:0]  seq_value;
    bfb_seq_req_t      seq_req;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            da_addr_reg <= DA_ADDR_RST;
            channel_reg <= CHANNEL_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DA_ADDR: da_addr_reg <= wr_data[MAC_W-1:0];
                REG_CHANNEL: channel_reg <= wr_data[CHAN_W-1:0];
                default:     ;
            endcase
        end
    end

    // per-slot sequence numbers
    bfb_seq_table u_seq_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_slot (req.network_slot),
        .rd_seq  (seq_value),
        .req     (seq_req)
    );

    // frame assembly and word output
    bfb_word_gen u_word_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .da_addr   (da_addr_reg),
        .channel   (channel_reg),
        .seq_value (seq_value),
        .seq_req   (seq_req),
        .req       (req),
        .frame     (frame)
    );

endmodule

`default_nettype wire
